>>> rtl/core/isl_pkg.sv
// Shared types, constants and the sequencer microcode for the impeller speed loop.
`timescale 1ns / 1ps
`default_nettype none

package isl_pkg;

  // Number format: signed Q16.32 in 48 bits
  localparam int Q_W    = 48;
  localparam int FRAC_W = 32;
  localparam int CFG_W  = 41;
  localparam int CMD_W  = 8;
  localparam int VBAT_W = 38;
  localparam int IDX_W  = 3;
  localparam int HALF_W = Q_W / 2;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Fixed model constants, Q16.32
  localparam q_t K_DT     = 48'sd68719477;
  localparam q_t K_INV_KS = 48'sd109662877;
  localparam q_t K_INV_R  = 48'sd3579139413;
  localparam q_t K_KT     = 48'sd109521666;
  localparam q_t K_BF     = 48'sd34384;
  localparam q_t K_ACCEL  = 48'sd68719476736;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_KP    = 41'd858993459;
  localparam logic [CFG_W-1:0] RST_KI    = 41'd429496730;
  localparam logic [CFG_W-1:0] RST_KD    = 41'd214748365;
  localparam logic [CFG_W-1:0] RST_DRIVE = 41'd71296457114;
  localparam logic [CFG_W-1:0] RST_SLEW  = 41'd1439256425;
  localparam logic [CFG_W-1:0] RST_SCALE = 41'd5422284542;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_KP    = 3'd0,
    REG_KI    = 3'd1,
    REG_KD    = 3'd2,
    REG_DRIVE = 3'd3,
    REG_SLEW  = 3'd4,
    REG_SCALE = 3'd5
  } cfg_reg_t;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_MIN,
    OP_MAX,
    OP_END
  } op_t;

  // Operand sources
  typedef enum logic [4:0] {
    SRC_CMD, SRC_SCALE, SRC_RS, SRC_SLEW, SRC_SP, SRC_WS, SRC_T, SRC_T2,
    SRC_TRK, SRC_KP, SRC_KD, SRC_KI, SRC_ERR, SRC_INTEG, SRC_D, SRC_KDT,
    SRC_U, SRC_NDRIVE, SRC_DRIVE, SRC_VBAT, SRC_NVBAT, SRC_KINVKS, SRC_KINVR,
    SRC_CUR, SRC_KKT, SRC_KBF, SRC_TRQ, SRC_KACCEL
  } src_t;

  // Write-back destinations
  typedef enum logic [3:0] {
    DST_SP, DST_T, DST_T2, DST_RS, DST_ERR, DST_D, DST_U, DST_TRK,
    DST_INTEG, DST_CUR, DST_TRQ, DST_WS
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  localparam int UCODE_LEN = 29;
  localparam int PC_W      = $clog2(UCODE_LEN);

  // Multiplier handshake
  typedef struct packed {
    logic start;
    q_t   a;
    q_t   b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    q_t   result;
  } mul_rsp_t;

  // One control tick as a micro-program
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // command conversion and slew limit
      5'd0:  u = '{OP_MUL, SRC_CMD,    SRC_SCALE,  DST_SP};
      5'd1:  u = '{OP_ADD, SRC_RS,     SRC_SLEW,   DST_T};
      5'd2:  u = '{OP_SUB, SRC_RS,     SRC_SLEW,   DST_T2};
      5'd3:  u = '{OP_MIN, SRC_SP,     SRC_T,      DST_SP};
      5'd4:  u = '{OP_MAX, SRC_SP,     SRC_T2,     DST_RS};
      5'd5:  u = '{OP_SUB, SRC_RS,     SRC_WS,     DST_ERR};
      // PID with filtered derivative
      5'd6:  u = '{OP_MUL, SRC_KD,     SRC_ERR,    DST_T};
      5'd7:  u = '{OP_SUB, SRC_T,      SRC_TRK,    DST_D};
      5'd8:  u = '{OP_MUL, SRC_KP,     SRC_ERR,    DST_T};
      5'd9:  u = '{OP_MUL, SRC_KI,     SRC_INTEG,  DST_T2};
      5'd10: u = '{OP_ADD, SRC_T,      SRC_T2,     DST_U};
      5'd11: u = '{OP_ADD, SRC_U,      SRC_D,      DST_U};
      5'd12: u = '{OP_MUL, SRC_D,      SRC_KDT,    DST_T};
      5'd13: u = '{OP_ADD, SRC_TRK,    SRC_T,      DST_TRK};
      5'd14: u = '{OP_MUL, SRC_ERR,    SRC_KDT,    DST_T};
      5'd15: u = '{OP_ADD, SRC_INTEG,  SRC_T,      DST_INTEG};
      // drive clamp and battery clamp
      5'd16: u = '{OP_MAX, SRC_U,      SRC_NDRIVE, DST_U};
      5'd17: u = '{OP_MIN, SRC_U,      SRC_DRIVE,  DST_U};
      5'd18: u = '{OP_MIN, SRC_U,      SRC_VBAT,   DST_U};
      5'd19: u = '{OP_MAX, SRC_U,      SRC_NVBAT,  DST_U};
      // DC motor model
      5'd20: u = '{OP_MUL, SRC_WS,     SRC_KINVKS, DST_T};
      5'd21: u = '{OP_SUB, SRC_U,      SRC_T,      DST_T};
      5'd22: u = '{OP_MUL, SRC_T,      SRC_KINVR,  DST_CUR};
      5'd23: u = '{OP_MUL, SRC_CUR,    SRC_KKT,    DST_T};
      5'd24: u = '{OP_MUL, SRC_KBF,    SRC_WS,     DST_T2};
      5'd25: u = '{OP_SUB, SRC_T,      SRC_T2,     DST_TRQ};
      5'd26: u = '{OP_MUL, SRC_TRQ,    SRC_KACCEL, DST_T};
      5'd27: u = '{OP_ADD, SRC_WS,     SRC_T,      DST_WS};
      default: u = '{OP_END, SRC_WS,   SRC_WS,     DST_WS};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/isl_if.sv
// Valid/ready channels for control ticks and motor results.
`timescale 1ns / 1ps
`default_nettype none

interface isl_cmd_if;
  import isl_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    speed_command;
  logic [VBAT_W-1:0]   battery_voltage;

  modport source (output valid, output speed_command, output battery_voltage, input ready);
  modport sink   (input valid, input speed_command, input battery_voltage, output ready);
endinterface

interface isl_res_if;
  import isl_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [Q_W-1:0] coil_current;
  logic signed [Q_W-1:0] shaft_torque;
  logic signed [Q_W-1:0] rotor_speed;

  modport source (output valid, output coil_current, output shaft_torque,
                  output rotor_speed, input ready);
  modport sink   (input valid, input coil_current, input shaft_torque,
                  input rotor_speed, output ready);
endinterface

`default_nettype wire

>>> rtl/core/impeller_speed_loop_model.sv
// Top level of the impeller speed loop: sequencer, shared ALU, state and ports.
`timescale 1ns / 1ps
`default_nettype none

// Impeller speed loop. One transfer on cmd is one control tick; one result transfer
// on res follows with coil current, shaft torque and the new rotor speed (all Q16.32).
// An item runs as a 28-step micro-program over one shared adder/compare unit and one
// shared multiplier that builds each 48x48 product from four 24x24 partial products.
// Each of the eleven products waits in S_MULW for the multiplier, and each add, subtract
// or clamp writes back straight from S_EXEC. After the end step and the hand-off the
// result is offered and cmd is ready again in that same cycle, so a new tick is taken
// only once the previous one has been handed off. A result waiting on res does not hold up the next
// tick's arithmetic; only the hand-off at its end waits for the output register.
// Configuration writes take effect at once and belong between ticks.
module impeller_speed_loop_model (
  input  wire logic                       clk,
  input  wire logic                       rst,
  isl_cmd_if.sink                         cmd,
  isl_res_if.source                       res,
  input  wire logic                       cfg_we,
  input  wire logic [isl_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [isl_pkg::CFG_W-1:0]  cfg_data
);
  import isl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MULW = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [PC_W-1:0]   pc;

  // configuration
  logic [CFG_W-1:0]  gain_p;
  logic [CFG_W-1:0]  gain_i;
  logic [CFG_W-1:0]  gain_d;
  logic [CFG_W-1:0]  drive_lim;
  logic [CFG_W-1:0]  slew_lim;
  logic [CFG_W-1:0]  speed_scale;

  // loop state
  q_t ramped_setpoint;
  q_t wheel_speed;
  q_t derivative_track;
  q_t error_integral;

  // per-tick working values
  q_t cmd_q;
  q_t vbat;
  q_t setpoint;
  q_t error_val;
  q_t deriv;
  q_t drive;
  q_t tmp_a;
  q_t tmp_b;
  q_t current;
  q_t torque;

  // output register
  logic out_valid;
  q_t   out_current;
  q_t   out_torque;
  q_t   out_speed;
  logic out_free;

  uop_t              uop;
  q_t                opa;
  q_t                opb;
  logic signed [Q_W:0] sum_wide;
  q_t                alu_res;
  logic              wb_en;
  q_t                wb_val;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  // operand select
  function automatic q_t pick(input src_t s);
    q_t v;
    unique case (s)
      SRC_CMD:    v = cmd_q;
      SRC_SCALE:  v = $signed({{(Q_W-CFG_W){1'b0}}, speed_scale});
      SRC_RS:     v = ramped_setpoint;
      SRC_SLEW:   v = $signed({{(Q_W-CFG_W){1'b0}}, slew_lim});
      SRC_SP:     v = setpoint;
      SRC_WS:     v = wheel_speed;
      SRC_T:      v = tmp_a;
      SRC_T2:     v = tmp_b;
      SRC_TRK:    v = derivative_track;
      SRC_KP:     v = $signed({{(Q_W-CFG_W){1'b0}}, gain_p});
      SRC_KD:     v = $signed({{(Q_W-CFG_W){1'b0}}, gain_d});
      SRC_KI:     v = $signed({{(Q_W-CFG_W){1'b0}}, gain_i});
      SRC_ERR:    v = error_val;
      SRC_INTEG:  v = error_integral;
      SRC_D:      v = deriv;
      SRC_KDT:    v = K_DT;
      SRC_U:      v = drive;
      SRC_NDRIVE: v = $signed(Q_W'(0) - {{(Q_W-CFG_W){1'b0}}, drive_lim});
      SRC_DRIVE:  v = $signed({{(Q_W-CFG_W){1'b0}}, drive_lim});
      SRC_VBAT:   v = vbat;
      SRC_NVBAT:  v = $signed(Q_W'(0) - vbat);
      SRC_KINVKS: v = K_INV_KS;
      SRC_KINVR:  v = K_INV_R;
      SRC_CUR:    v = current;
      SRC_KKT:    v = K_KT;
      SRC_KBF:    v = K_BF;
      SRC_TRQ:    v = torque;
      SRC_KACCEL: v = K_ACCEL;
      default:    v = '0;
    endcase
    return v;
  endfunction

  // shared add/subtract/compare unit with saturation
  always_comb begin
    uop = ucode(pc);
    opa = pick(uop.a);
    opb = pick(uop.b);
    if (uop.op == OP_SUB) begin
      sum_wide = {opa[Q_W-1], opa} - {opb[Q_W-1], opb};
    end else begin
      sum_wide = {opa[Q_W-1], opa} + {opb[Q_W-1], opb};
    end
    unique case (uop.op)
      OP_MIN:  alu_res = (opa > opb) ? opb : opa;
      OP_MAX:  alu_res = (opa < opb) ? opb : opa;
      OP_ADD,
      OP_SUB: begin
        if (sum_wide[Q_W] != sum_wide[Q_W-1]) begin
          alu_res = sum_wide[Q_W] ? Q_MIN : Q_MAX;
        end else begin
          alu_res = sum_wide[Q_W-1:0];
        end
      end
      default: alu_res = opa;
    endcase
  end

  // multiplier issue and write-back
  always_comb begin
    mul_req.start = (state == S_EXEC) && (uop.op == OP_MUL);
    mul_req.a     = opa;
    mul_req.b     = opb;
    wb_en  = 1'b0;
    wb_val = alu_res;
    if (state == S_EXEC && uop.op != OP_MUL && uop.op != OP_END) begin
      wb_en = 1'b1;
    end else if (state == S_MULW && mul_rsp.done) begin
      wb_en  = 1'b1;
      wb_val = mul_rsp.result;
    end
  end

  isl_qmul u_qmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // sequencer
  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (uop.op == OP_MUL) begin
          state_next = S_MULW;
        end else if (uop.op == OP_END) begin
          state_next = S_OUT;
        end
      end
      S_MULW: if (mul_rsp.done) state_next = S_EXEC;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        pc <= '0;
      end else if (wb_en) begin
        pc <= pc + PC_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= RST_KP;
      gain_i      <= RST_KI;
      gain_d      <= RST_KD;
      drive_lim   <= RST_DRIVE;
      slew_lim    <= RST_SLEW;
      speed_scale <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:    gain_p      <= cfg_data;
        REG_KI:    gain_i      <= cfg_data;
        REG_KD:    gain_d      <= cfg_data;
        REG_DRIVE: drive_lim   <= cfg_data;
        REG_SLEW:  slew_lim    <= cfg_data;
        REG_SCALE: speed_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // loop state, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ramped_setpoint  <= '0;
      wheel_speed      <= '0;
      derivative_track <= '0;
      error_integral   <= '0;
    end else if (wb_en) begin
      case (uop.dst)
        DST_RS:    ramped_setpoint  <= wb_val;
        DST_WS:    wheel_speed      <= wb_val;
        DST_TRK:   derivative_track <= wb_val;
        DST_INTEG: error_integral   <= wb_val;
        default: ;
      endcase
    end
  end

  // tick inputs and working values
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= {{(Q_W-FRAC_W-CMD_W){1'b0}}, cmd.speed_command, {FRAC_W{1'b0}}};
      vbat  <= {{(Q_W-VBAT_W){1'b0}}, cmd.battery_voltage};
    end
    if (wb_en) begin
      case (uop.dst)
        DST_SP:  setpoint  <= wb_val;
        DST_T:   tmp_a     <= wb_val;
        DST_T2:  tmp_b     <= wb_val;
        DST_ERR: error_val <= wb_val;
        DST_D:   deriv     <= wb_val;
        DST_U:   drive     <= wb_val;
        DST_CUR: current   <= wb_val;
        DST_TRQ: torque    <= wb_val;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_current <= current;
      out_torque  <= torque;
      out_speed   <= wheel_speed;
    end
  end

  assign res.valid        = out_valid;
  assign res.coil_current = out_current;
  assign res.shaft_torque = out_torque;
  assign res.rotor_speed  = out_speed;

  // checks
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == S_MULW)
    else $error("product arrived while the sequencer was not waiting");
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC || state == S_MULW) |-> pc < PC_W'(UCODE_LEN))
    else $error("micro-program counter ran past the end");
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> res.valid && state == S_IDLE)
    else $error("result hand-off did not complete");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(cmd_q))
    else $error("tick input changed during processing");

endmodule

`default_nettype wire

>>> rtl/core/isl_qmul.sv
// Iterative Q16.32 multiplier: 24x24 partial products, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module isl_qmul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire isl_pkg::mul_req_t req,
  output      isl_pkg::mul_rsp_t rsp
);
  import isl_pkg::*;

  localparam int ACC_W = 2 * Q_W;

  logic [Q_W-1:0]      mag_a;
  logic [Q_W-1:0]      mag_b;
  logic                neg;
  logic [ACC_W-1:0]    acc;
  logic [1:0]          step;
  logic                busy;
  logic                fin;
  logic                done_q;
  q_t                  result_q;

  logic [HALF_W-1:0]   pp_a;
  logic [HALF_W-1:0]   pp_b;
  logic [Q_W-1:0]      pp;
  logic [ACC_W-1:0]    pp_sh;
  logic [ACC_W-FRAC_W-1:0] rnd;
  q_t                  sat_val;

  // partial product select: low/low, low/high, high/low, high/high
  always_comb begin
    unique case (step)
      2'd0: begin
        pp_a = mag_a[HALF_W-1:0];
        pp_b = mag_b[HALF_W-1:0];
      end
      2'd1: begin
        pp_a = mag_a[HALF_W-1:0];
        pp_b = mag_b[Q_W-1:HALF_W];
      end
      2'd2: begin
        pp_a = mag_a[Q_W-1:HALF_W];
        pp_b = mag_b[HALF_W-1:0];
      end
      default: begin
        pp_a = mag_a[Q_W-1:HALF_W];
        pp_b = mag_b[Q_W-1:HALF_W];
      end
    endcase
    pp = pp_a * pp_b;
    unique case (step)
      2'd0:    pp_sh = {{Q_W{1'b0}}, pp};
      2'd1,
      2'd2:    pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
      default: pp_sh = {pp, {Q_W{1'b0}}};
    endcase
  end

  // drop the fraction, saturate on the magnitude, then apply the sign
  always_comb begin
    rnd = acc[ACC_W-1:FRAC_W];
    if (|rnd[ACC_W-FRAC_W-1:Q_W-1]) begin
      sat_val = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      sat_val = $signed(Q_W'(0) - {1'b0, rnd[Q_W-2:0]});
    end else begin
      sat_val = $signed({1'b0, rnd[Q_W-2:0]});
    end
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_q <= 1'b0;
      step   <= 2'd0;
    end else begin
      done_q <= fin;
      fin    <= busy && (step == 2'd3);
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // operands, accumulator and result
  always_ff @(posedge clk) begin
    if (req.start) begin
      mag_a <= req.a[Q_W-1] ? (Q_W'(0) - req.a) : req.a;
      mag_b <= req.b[Q_W-1] ? (Q_W'(0) - req.b) : req.b;
      neg   <= req.a[Q_W-1] ^ req.b[Q_W-1];
      acc   <= ACC_W'(1) << (FRAC_W - 1);
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
    if (fin) begin
      result_q <= sat_val;
    end
  end

  assign rsp = '{done: done_q, result: result_q};

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy && !fin && !done_q)
    else $error("multiplier restarted while busy");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && step == 2'd3 && !req.start) |=> fin && !busy)
    else $error("multiplier did not finish after the last partial product");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    fin |=> done_q)
    else $error("multiplier result not flagged done");

endmodule

`default_nettype wire
